// ===== hdl/bpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  localparam int NUM_CHANNELS = 8;

  // register indexes
  localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_NORMAL     = 2'd2;
  localparam logic [1:0] REG_ENABLE     = 2'd3;

  localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;

  // phase codes of the per-channel machine
  localparam logic [3:0] PH_PRESS_EVT   = 4'd0;
  localparam logic [3:0] PH_SREL_EVT    = 4'd1;
  localparam logic [3:0] PH_LREL_EVT    = 4'd2;
  localparam logic [3:0] PH_PRESSED     = 4'd3;
  localparam logic [3:0] PH_LONGPRESSED = 4'd4;
  localparam logic [3:0] PH_SRELEASED   = 4'd5;
  localparam logic [3:0] PH_LRELEASED   = 4'd6;
  localparam logic [3:0] PH_PRESS_PRE   = 4'd7;
  localparam logic [3:0] PH_SHORT_REL   = 4'd8;
  localparam logic [3:0] PH_LONG_REL    = 4'd9;
  localparam logic [3:0] PH_IDLE        = 4'd10;
  localparam logic [3:0] PH_PRESS_AFT   = 4'd11;
  localparam logic [3:0] PH_HOLDING     = 4'd12;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_PRESSED   = 3'd1;
  localparam logic [2:0] EV_LONG      = 3'd2;
  localparam logic [2:0] EV_SHORT_REL = 3'd3;
  localparam logic [2:0] EV_LONG_REL  = 3'd4;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_HOLDING  = 2'd2;
  localparam logic [1:0] ST_DISABLED = 2'd3;

  typedef struct packed {
    logic [2:0]  channel;
    logic        level;
    logic [15:0] now_time;
  } item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [1:0] stable_state;
  } result_t;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] long_press_ticks;
    logic [7:0]  normal_level_mask;
    logic [7:0]  enable_mask;
    logic [7:0]  phase_clear;
  } cfg_t;

  // col[0]: pressed level, col[1]: timeout
  function automatic logic [3:0] next_phase(input logic [3:0] p, input logic [1:0] col);
    logic [3:0] n;
    case (p) inside
      PH_PRESS_EVT:               n = PH_PRESS_PRE;
      PH_SREL_EVT:                n = PH_SHORT_REL;
      PH_LREL_EVT:                n = PH_LONG_REL;
      PH_PRESSED:                 n = PH_PRESS_AFT;
      PH_LONGPRESSED:             n = PH_HOLDING;
      PH_SRELEASED, PH_LRELEASED: n = PH_IDLE;
      PH_PRESS_PRE: n = col[0] ? (col[1] ? PH_PRESSED : PH_PRESS_PRE) : PH_IDLE;
      PH_SHORT_REL: n = col[0] ? PH_PRESS_AFT : (col[1] ? PH_SRELEASED : PH_SHORT_REL);
      PH_LONG_REL:  n = col[0] ? PH_HOLDING : (col[1] ? PH_LRELEASED : PH_LONG_REL);
      PH_PRESS_AFT: n = col[0] ? (col[1] ? PH_LONGPRESSED : PH_PRESS_AFT) : PH_SREL_EVT;
      PH_HOLDING:   n = col[0] ? PH_HOLDING : (col[1] ? PH_LRELEASED : PH_LREL_EVT);
      default:      n = col[0] ? (col[1] ? PH_PRESSED : PH_PRESS_EVT) : PH_IDLE;
    endcase
    return n;
  endfunction

  // debounce phases report the state they fall back to
  function automatic logic [1:0] stable_code(input logic [3:0] p);
    logic [1:0] s;
    case (p) inside
      PH_SHORT_REL, PH_PRESS_AFT: s = ST_SHORT;
      PH_LONG_REL, PH_HOLDING:    s = ST_HOLDING;
      default:                    s = ST_IDLE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bpc_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpc_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  output bpc_pkg::cfg_t          cfg
);

  logic [15:0] debounce_ticks;
  logic [15:0] long_press_ticks;
  logic [7:0]  normal_level_mask;
  logic [7:0]  enable_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks    <= bpc_pkg::DEBOUNCE_RESET;
      long_press_ticks  <= bpc_pkg::LONG_PRESS_RESET;
      normal_level_mask <= '0;
      enable_mask       <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpc_pkg::REG_DEBOUNCE:   debounce_ticks    <= cfg_data;
        bpc_pkg::REG_LONG_PRESS: long_press_ticks  <= cfg_data;
        bpc_pkg::REG_NORMAL:     normal_level_mask <= cfg_data[7:0];
        bpc_pkg::REG_ENABLE:     enable_mask       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.debounce_ticks    = debounce_ticks;
    cfg.long_press_ticks  = long_press_ticks;
    cfg.normal_level_mask = normal_level_mask;
    cfg.enable_mask       = enable_mask;
    // send channels whose enable bit flips back to idle
    cfg.phase_clear = (cfg_we && cfg_index == bpc_pkg::REG_ENABLE)
                      ? (cfg_data[7:0] ^ enable_mask) : 8'd0;
  end

endmodule

`default_nettype wire

// ===== hdl/bpc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpc_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire bpc_pkg::item_t    item,
  input  wire bpc_pkg::cfg_t     cfg,
  output bpc_pkg::result_t       result
);

  logic [3:0]  phase          [bpc_pkg::NUM_CHANNELS];
  logic [15:0] debounce_start [bpc_pkg::NUM_CHANNELS];
  logic [15:0] long_press_start [bpc_pkg::NUM_CHANNELS];

  logic        active;
  logic [3:0]  p;
  logic [3:0]  phase_next;
  logic [15:0] db_elapsed;
  logic [15:0] lp_elapsed;
  logic        tmo;
  logic        pressed;
  logic        write_db;
  logic        write_lp;

  always_comb begin
    active = (32'(item.channel) < bpc_pkg::NUM_CHANNELS) && cfg.enable_mask[item.channel];
    p = phase[item.channel];
    if (p > bpc_pkg::PH_HOLDING) begin
      p = bpc_pkg::PH_IDLE;
    end
    db_elapsed = item.now_time - debounce_start[item.channel];
    lp_elapsed = item.now_time - long_press_start[item.channel];
    pressed = item.level ^ cfg.normal_level_mask[item.channel];

    tmo = 1'b0;
    if (p >= bpc_pkg::PH_PRESS_PRE && p <= bpc_pkg::PH_LONG_REL) begin
      tmo = db_elapsed >= cfg.debounce_ticks;
    end else if (p == bpc_pkg::PH_PRESS_AFT) begin
      tmo = lp_elapsed >= cfg.long_press_ticks;
    end
    phase_next = bpc_pkg::next_phase(p, {tmo, pressed});

    write_db = active && p < bpc_pkg::PH_PRESSED;
    write_lp = active && p == bpc_pkg::PH_PRESSED;

    result.event_res = bpc_pkg::EV_NONE;
    case (p)
      bpc_pkg::PH_PRESSED:     result.event_res = bpc_pkg::EV_PRESSED;
      bpc_pkg::PH_LONGPRESSED: result.event_res = bpc_pkg::EV_LONG;
      bpc_pkg::PH_SRELEASED:   result.event_res = bpc_pkg::EV_SHORT_REL;
      bpc_pkg::PH_LRELEASED:   result.event_res = bpc_pkg::EV_LONG_REL;
      default: ;
    endcase
    // transient phases report the phase they pass to
    result.stable_state = bpc_pkg::stable_code(
        (p < bpc_pkg::PH_PRESS_PRE) ? bpc_pkg::next_phase(p, 2'b00) : p);

    if (!active) begin
      result.event_res    = bpc_pkg::EV_NONE;
      result.stable_state = bpc_pkg::ST_DISABLED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < bpc_pkg::NUM_CHANNELS; c++) begin
        phase[c] <= bpc_pkg::PH_IDLE;
      end
    end else begin
      if (fire && active) begin
        phase[item.channel] <= phase_next;
      end
      for (int c = 0; c < bpc_pkg::NUM_CHANNELS; c++) begin
        if (cfg.phase_clear[c]) begin
          phase[c] <= bpc_pkg::PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && write_db) begin
      debounce_start[item.channel] <= item.now_time;
    end
    if (fire && write_lp) begin
      long_press_start[item.channel] <= item.now_time;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/button_press_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Polled button classifier for eight channels. Each request carries a channel,
// its raw level and a 16-bit time stamp, and returns one result: an event
// (pressed, long pressed, short released, long released) and the channel's
// stable state (idle, short pressed, holding, disabled). One request is taken
// every clock cycle while the result side is not stalled; the request is held
// in the input register and then its result in the result register, which
// holds it until it is taken. The per-channel phase and stamp registers are
// read, updated and written back between those two registers, so polls of
// the same channel may follow each other with no gap. Time differences wrap
// at 16 bits. Write the configuration registers only while no request is in
// flight; changing a channel's enable bit returns it to idle.
module button_press_classifier (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bpc_pkg::item_t    in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bpc_pkg::result_t       out_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);

  bpc_pkg::cfg_t    cfg;
  bpc_pkg::item_t   in_q;
  bpc_pkg::result_t result;
  logic             in_q_valid;
  logic             advance;
  logic             fire;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !advance;
  assign fire     = in_q_valid && advance;

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

  // hold a request in the input register while the result side is blocked
  assert property (@(posedge clk) disable iff (rst)
    in_q_valid && out_valid && out_stall |=> in_q_valid && $stable(in_q))
    else $error("input request dropped while output stalled");

  assert property (@(posedge clk) disable iff (rst)
    fire && !cfg.enable_mask[in_q.channel] |=>
      out_valid && out_data.event_res == bpc_pkg::EV_NONE &&
      out_data.stable_state == bpc_pkg::ST_DISABLED)
    else $error("disabled channel did not report disabled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_res != bpc_pkg::EV_NONE |->
      out_data.stable_state != bpc_pkg::ST_DISABLED &&
      out_data.event_res <= bpc_pkg::EV_LONG_REL)
    else $error("event reported with disabled state or bad code");

endmodule

`default_nettype wire
